### hw/rtl/rfr_pkg.sv
// Package for the ray versus floor rectangle intersection core.
// Holds widths, register indexes and the divider cell record; no dependencies.
package rfr_pkg;

    localparam int DVD_W    = 47;   // |num| (33 bits) scaled by 2^14
    localparam int Q_W      = 39;   // quotient bound: 2^46 / 164 < 2^39
    localparam int REM_W    = 17;
    localparam int ADY_W    = 16;
    localparam int N_CELLS  = Q_W;
    localparam logic [ADY_W-1:0] GRAZE_MAX  = 16'd163;  // |dir_y| <= 0.01
    localparam logic [Q_W-1:0]   SHADOW_MIN = 39'd655;  // 0.01 in Q16.16

    typedef enum logic [2:0] {
        REG_PLANE_HEIGHT = 3'd0,
        REG_CENTRE_X     = 3'd1,
        REG_CENTRE_Z     = 3'd2,
        REG_RECT_LENGTH  = 3'd3,
        REG_RECT_DEPTH   = 3'd4
    } rfr_reg_t;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [DVD_W-1:0]   dvd;
        logic [Q_W-1:0]     quo;
        logic [ADY_W-1:0]   ady;
        logic               kind;
        logic               miss;
        logic               up;
        logic signed [31:0] ox;
        logic signed [31:0] oz;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
    } rfr_div_t;

endpackage

### hw/rtl/rfr_div_cell.sv
// One restoring division cell: retires one quotient bit per request.
// Depends on rfr_pkg.
module rfr_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  rfr_pkg::rfr_div_t in_data,
    output logic             out_valid,
    output rfr_pkg::rfr_div_t out_data
);
    import rfr_pkg::*;

    logic             valid_reg;
    rfr_div_t         data_reg;
    rfr_div_t         data_next;
    logic [REM_W-1:0] r2;
    logic             ge;

    always_comb
    begin
        r2 = {in_data.rem[REM_W-2:0], in_data.dvd[DVD_W-1]};
        ge = (r2 >= {1'b0, in_data.ady});
        data_next      = in_data;
        data_next.rem  = ge ? (r2 - {1'b0, in_data.ady}) : r2;
        data_next.dvd  = {in_data.dvd[DVD_W-2:0], 1'b0};
        data_next.quo  = {in_data.quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

### hw/rtl/rfr_point.sv
// Hit point, bounds test and output register (three stages).
// Depends on rfr_pkg.
module rfr_point (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rfr_pkg::rfr_div_t  in_data,
    input  logic signed [31:0] centre_x,
    input  logic signed [31:0] centre_z,
    input  logic [30:0]        rect_length,
    input  logic [30:0]        rect_depth,
    output logic               out_valid,
    output logic               hit,
    output logic [30:0]        distance,
    output logic signed [31:0] hit_x,
    output logic signed [31:0] hit_z,
    output logic               normal_up
);
    import rfr_pkg::*;

    // stage 1: products
    logic               v1_reg;
    logic signed [55:0] prx_reg, prz_reg;
    logic [Q_W-1:0]     q1_reg;
    logic               k1_reg, m1_reg, u1_reg;
    logic signed [31:0] ox1_reg, oz1_reg;
    // stage 2: point
    logic               v2_reg;
    logic signed [42:0] px_reg, pz_reg;
    logic [Q_W-1:0]     q2_reg;
    logic               k2_reg, m2_reg, u2_reg;
    // stage 3 combinational
    logic signed [44:0] d2x, d2z, ex, ez;
    logic               outx, outz, miss_all;
    logic [30:0]        dist_sat;
    logic signed [31:0] sx, sz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= v2_reg;
        end
    end

    always_comb
    begin
        d2x = (45'(px_reg) - 45'(centre_x)) <<< 1;
        d2z = (45'(pz_reg) - 45'(centre_z)) <<< 1;
        ex  = $signed({14'd0, rect_length});
        ez  = $signed({14'd0, rect_depth});
        outx = (d2x < -ex) || (d2x > ex);
        outz = (d2z < -ez) || (d2z > ez);
        miss_all = m2_reg || (k2_reg && (q2_reg <= SHADOW_MIN)) || outx || outz;
        dist_sat = (q2_reg[Q_W-1:31] != '0) ? 31'h7FFF_FFFF : q2_reg[30:0];
        if (px_reg[42:31] != {12{px_reg[42]}})
            sx = px_reg[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sx = px_reg[31:0];
        if (pz_reg[42:31] != {12{pz_reg[42]}})
            sz = pz_reg[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sz = pz_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_reg <= $signed({1'b0, in_data.quo}) * in_data.dx;
            prz_reg <= $signed({1'b0, in_data.quo}) * in_data.dz;
            q1_reg  <= in_data.quo;
            k1_reg  <= in_data.kind;
            m1_reg  <= in_data.miss;
            u1_reg  <= in_data.up;
            ox1_reg <= in_data.ox;
            oz1_reg <= in_data.oz;
            // arithmetic shift is the floor of the scaled product
            px_reg  <= 43'(ox1_reg) + 43'($signed(prx_reg[55:14]));
            pz_reg  <= 43'(oz1_reg) + 43'($signed(prz_reg[55:14]));
            q2_reg  <= q1_reg;
            k2_reg  <= k1_reg;
            m2_reg  <= m1_reg;
            u2_reg  <= u1_reg;
            hit       <= !miss_all;
            distance  <= miss_all ? '0 : dist_sat;
            hit_x     <= miss_all ? '0 : sx;
            hit_z     <= miss_all ? '0 : sz;
            normal_up <= !miss_all && u2_reg;
        end
    end
endmodule

### hw/rtl/ray_floor_rect_intersect_core.sv
// Top level of the ray versus floor rectangle intersection core.
// Depends on rfr_pkg, rfr_div_cell and rfr_point.
//
// Tests one ray per clock against a horizontal rectangle. A request passes an
// entry stage, a row of 39 division cells (one quotient bit of t each) and
// three stages for the hit point, the bounds test and the output register.
// A new request is taken every cycle in which no result waits on m_tready.
// The whole pipeline holds while a result waits on m_tready.
module ray_floor_rect_intersect_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [143:0] s_tdata,
    // kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, distance, hit_x, hit_z, normal_up, zero pad
    output logic [103:0] m_tdata
);
    import rfr_pkg::*;

    logic signed [31:0] plane_height_reg, centre_x_reg, centre_z_reg;
    logic [30:0]        rect_length_reg, rect_depth_reg;

    logic               en;
    logic               v0_reg;
    rfr_div_t           d0_reg, d0_next;
    logic signed [32:0] num;
    logic [32:0]        anum;
    logic signed [15:0] dy;

    logic               cv [N_CELLS+1];
    rfr_div_t           cd [N_CELLS+1];

    logic               hit, normal_up;
    logic [30:0]        distance;
    logic signed [31:0] hit_x, hit_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_height_reg <= '0;
            centre_x_reg     <= '0;
            centre_z_reg     <= '0;
            rect_length_reg  <= '0;
            rect_depth_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PLANE_HEIGHT: plane_height_reg <= cfg_wdata;
                REG_CENTRE_X:     centre_x_reg     <= cfg_wdata;
                REG_CENTRE_Z:     centre_z_reg     <= cfg_wdata;
                REG_RECT_LENGTH:  rect_length_reg  <= cfg_wdata[30:0];
                REG_RECT_DEPTH:   rect_depth_reg   <= cfg_wdata[30:0];
                default:          ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        dy   = s_tdata[127:112];
        num  = 33'(plane_height_reg) - 33'($signed(s_tdata[63:32]));
        anum = num[32] ? 33'(-num) : 33'(num);
        d0_next.ady  = dy[15] ? ADY_W'(-dy) : ADY_W'(dy);
        d0_next.kind = s_tuser;
        // grazing ray or plane behind the origin
        d0_next.miss = (d0_next.ady <= GRAZE_MAX)
                       || ((num != '0) && (num[32] != dy[15]));
        d0_next.up   = (dy <= 16'sd0);
        d0_next.ox   = s_tdata[31:0];
        d0_next.oz   = s_tdata[95:64];
        d0_next.dx   = s_tdata[111:96];
        d0_next.dz   = s_tdata[143:128];
        // top bits stay below the divisor because the quotient fits Q_W bits
        d0_next.rem  = REM_W'(anum[32:25]);
        d0_next.dvd  = {anum[24:0], 22'd0};
        d0_next.quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg <= d0_next;
        end
    end

    assign cv[0] = v0_reg;
    assign cd[0] = d0_reg;

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        rfr_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_data  (cd[i+1])
        );
    end

    rfr_point u_point (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (cv[N_CELLS]),
        .in_data     (cd[N_CELLS]),
        .centre_x    (centre_x_reg),
        .centre_z    (centre_z_reg),
        .rect_length (rect_length_reg),
        .rect_depth  (rect_depth_reg),
        .out_valid   (m_tvalid),
        .hit         (hit),
        .distance    (distance),
        .hit_x       (hit_x),
        .hit_z       (hit_z),
        .normal_up   (normal_up)
    );

    assign m_tdata = {7'd0, normal_up, hit_z, hit_x, distance, hit};

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[103:1] == '0)
        else $error("miss result carries nonzero fields");
    a_rise_en: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result appeared while pipeline held");
    a_hit_up: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[96] |-> m_tdata[0])
        else $error("normal flag set on a miss");
endmodule
